@@ hw/rtl/srds_pkg.sv @@
package srds_pkg;

   localparam int DIST_W       = 16;
   localparam int LIMIT_W      = 14;
   localparam int PERIOD_W     = 8;
   localparam int BYTE_W       = 8;
   localparam int SEG_W        = 8;
   localparam int POS_W        = 2;
   localparam int DIGIT_W      = 4;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 14;
   localparam int VAL_W        = 14;
   localparam int RECIP_W      = 24;
   localparam int RECIP_SHIFT  = 23;
   localparam int PROD_W       = VAL_W + RECIP_W;
   localparam int DIV10_W      = 16;
   localparam int DIV10_SHIFT  = 19;
   localparam int DIV10_PROD_W = VAL_W + DIV10_W;
   localparam int Q10_W        = DIV10_PROD_W - DIV10_SHIFT;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LIMIT    = 1'b1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd100;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 14'd4500;
   localparam logic [BYTE_W-1:0]   TRIGGER_CODE = 8'h55;
   localparam logic [SEG_W-1:0]    DASH_CODE    = 8'h40;
   localparam logic [DIV10_W-1:0]  DIV10_RECIP  = 16'd52429;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [POS_W-1:0]  pos;
      logic              trig;
   } srds_entry_type;

   function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] code;
      case (digit)
         4'd0:    code = 8'h3F;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5B;
         4'd3:    code = 8'h4F;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6D;
         4'd6:    code = 8'h7D;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h6F;
         default: code = DASH_CODE;
      endcase
      return code;
   endfunction

   function automatic logic [SEG_W-1:0] enable_code(input logic [POS_W-1:0] pos);
      logic [SEG_W-1:0] code;
      case (pos)
         2'd0:    code = 8'hEF;
         2'd1:    code = 8'hDF;
         2'd2:    code = 8'hBF;
         default: code = 8'h7F;
      endcase
      return code;
   endfunction

   // scaled reciprocals of 1000, 100, 10 and 1, exact for values below 2**14
   function automatic logic [RECIP_W-1:0] recip_code(input logic [POS_W-1:0] pos);
      logic [RECIP_W-1:0] code;
      case (pos)
         2'd0:    code = 24'd8389;
         2'd1:    code = 24'd83887;
         2'd2:    code = 24'd838861;
         default: code = 24'd8388608;
      endcase
      return code;
   endfunction

endpackage

@@ hw/rtl/srds_if.sv @@
interface srds_req_if import srds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface srds_rsp_if import srds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SEG_W-1:0]  segments;
   logic [SEG_W-1:0]  digit_enable;
   logic              send_trigger;
   logic [BYTE_W-1:0] trigger_byte;

   modport source (output valid, output segments, output digit_enable,
                   output send_trigger, output trigger_byte, input ready);
   modport sink (input valid, input segments, input digit_enable,
                 input send_trigger, input trigger_byte, output ready);
endinterface

interface srds_csr_if import srds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hw/rtl/srds_front.sv @@
module srds_front import srds_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   srds_req_if.sink           req_ch,
   srds_csr_if.sink           csr_ch,
   input  logic               push_ready,
   output logic               push_valid,
   output srds_entry_type     push_entry,
   output logic [LIMIT_W-1:0] range_limit
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic                slot_ff, slot_in;
   logic [BYTE_W-1:0]   high_ff, high_in;
   logic [BYTE_W-1:0]   low_ff, low_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [PERIOD_W-1:0] count_ff, count_in;
   logic [PERIOD_W-1:0] count_next;
   logic                accept;
   logic                trig;

   assign req_ch.ready = push_ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign count_next   = count_ff + 1'b1;
   assign trig         = (count_next == period_ff);

   assign push_valid          = accept && (req_ch.op == OP_TICK);
   assign push_entry.distance = {high_ff, low_ff};
   assign push_entry.pos      = pos_ff;
   assign push_entry.trig     = trig;
   assign range_limit         = limit_ff;

   always_comb begin
      period_in = period_ff;
      limit_in  = limit_ff;
      slot_in   = slot_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_TRIGGER_PERIOD: period_in = csr_ch.wdata[PERIOD_W-1:0];
            CSR_RANGE_LIMIT:    limit_in  = csr_ch.wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
      if (accept) begin
         if (req_ch.op == OP_BYTE) begin
            if (slot_ff) begin
               low_in = req_ch.rx_byte;
            end else begin
               high_in = req_ch.rx_byte;
            end
            slot_in = !slot_ff;
         end else begin
            pos_in   = pos_ff + 1'b1;
            count_in = trig ? '0 : count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         limit_ff  <= LIMIT_RESET;
         slot_ff   <= 1'b0;
         high_ff   <= '0;
         low_ff    <= '0;
         pos_ff    <= '0;
         count_ff  <= '0;
      end else begin
         period_ff <= period_in;
         limit_ff  <= limit_in;
         slot_ff   <= slot_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/srds_queue.sv @@
module srds_queue import srds_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  srds_entry_type in_entry,
   output logic           out_valid,
   input  logic           out_ready,
   output srds_entry_type out_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   srds_entry_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/srds_back.sv @@
module srds_back import srds_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  srds_entry_type     in_entry,
   input  logic [LIMIT_W-1:0] range_limit,
   srds_rsp_if.source         rsp_ch
);

   logic                    a_valid_ff, b_valid_ff, c_valid_ff;
   logic                    en_a, en_b, en_c;
   logic [PROD_W-1:0]       a_prod_ff, a_prod_in;
   logic                    a_dash_ff, a_dash_in;
   logic [POS_W-1:0]        a_pos_ff, b_pos_ff;
   logic                    a_trig_ff, b_trig_ff;
   logic [VAL_W-1:0]        b_q_ff, b_q_in;
   logic [DIV10_PROD_W-1:0] b_prod_ff, b_prod_in;
   logic                    b_dash_ff;
   logic [Q10_W-1:0]        q10;
   logic [VAL_W-1:0]        rem;
   logic [SEG_W-1:0]        seg_ff, seg_in;
   logic [SEG_W-1:0]        enable_ff;
   logic                    trig_ff;

   assign en_c     = !c_valid_ff || rsp_ch.ready;
   assign en_b     = !b_valid_ff || en_c;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;

   // divide by the place value of the digit
   assign a_dash_in = (in_entry.distance > DIST_W'(range_limit));
   assign a_prod_in = PROD_W'(in_entry.distance[VAL_W-1:0])
                      * PROD_W'(recip_code(in_entry.pos));

   // take the quotient modulo ten
   assign b_q_in    = a_prod_ff[RECIP_SHIFT +: VAL_W];
   assign b_prod_in = DIV10_PROD_W'(b_q_in) * DIV10_PROD_W'(DIV10_RECIP);

   assign q10    = b_prod_ff[DIV10_SHIFT +: Q10_W];
   assign rem    = b_q_ff - (VAL_W'({q10, 3'b000}) + VAL_W'({q10, 1'b0}));
   assign seg_in = b_dash_ff ? DASH_CODE : seg_code(rem[DIGIT_W-1:0]);

   assign rsp_ch.valid        = c_valid_ff;
   assign rsp_ch.segments     = seg_ff;
   assign rsp_ch.digit_enable = enable_ff;
   assign rsp_ch.send_trigger = trig_ff;
   assign rsp_ch.trigger_byte = TRIGGER_CODE;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= in_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (en_c) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_prod_ff <= a_prod_in;
         a_dash_ff <= a_dash_in;
         a_pos_ff  <= in_entry.pos;
         a_trig_ff <= in_entry.trig;
      end
      if (en_b) begin
         b_q_ff    <= b_q_in;
         b_prod_ff <= b_prod_in;
         b_dash_ff <= a_dash_ff;
         b_pos_ff  <= a_pos_ff;
         b_trig_ff <= a_trig_ff;
      end
      if (en_c) begin
         seg_ff    <= seg_in;
         enable_ff <= enable_code(b_pos_ff);
         trig_ff   <= b_trig_ff;
      end
   end

endmodule

@@ hw/rtl/serial_range_display_scanner.sv @@
// A tick request gives its result once it has passed the queue and the A, B and
// C digit stages; a byte request gives no result.
// Throughput: one request per cycle while the queue has room, set by the three-stage digit pipeline.
// Reset (synchronous, active high): distance, scan position, tick count and
// queue clear; trigger_period resets to 100 and range_limit to 4500.
module serial_range_display_scanner import srds_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   srds_req_if.sink   req_ch,
   srds_rsp_if.source rsp_ch,
   srds_csr_if.sink   csr_ch
);

   logic               push_valid, push_ready;
   srds_entry_type     push_entry;
   logic               pop_valid, pop_ready;
   srds_entry_type     pop_entry;
   logic [LIMIT_W-1:0] range_limit;

   srds_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .range_limit (range_limit)
   );

   srds_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   srds_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pop_valid),
      .in_ready    (pop_ready),
      .in_entry    (pop_entry),
      .range_limit (range_limit),
      .rsp_ch      (rsp_ch)
   );

   a_byte_no_push: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == OP_BYTE) |-> !push_valid)
      else $error("byte request pushed into queue");

   a_tick_push: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == OP_TICK) |-> push_ready && push_valid)
      else $error("tick request lost");

   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ($countones(~rsp_ch.digit_enable) == 1))
      else $error("digit enable not one-cold");

   a_dash_range: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && pop_entry.distance <= DIST_W'(range_limit))
      |=> !u_back.a_dash_ff)
      else $error("in-range distance marked as dash");

endmodule
